FILE: design/chord_arp_pkg.sv
// Shared types, codes and constants of the chord arpeggiator.
// Used by the channel interfaces, the cells, the remainder unit and the top level.
package chord_arp_pkg;

  localparam int MAX_HELD_DEF   = 8;
  localparam int MAX_STEPS_DEF  = 16;
  localparam int MAX_RESULTS    = 16;

  localparam int NOTE_W         = 7;
  localparam int VEL_W          = 7;
  localparam int REQ_W          = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int STEP_TABLE_W   = 64;
  localparam int TICK_W         = 15;
  localparam int STEP_DIV_W     = 13;

  localparam int TICKS_PER_STEP = 6;
  localparam int TICK_WRAP      = 24000;
  localparam int SEMIS_PER_OCT  = 12;

  localparam logic [VEL_W-1:0] VEL_RESET = 7'd100;

  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ACCOMP_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARP_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_STEPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TABLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_SHIFT   = 3'd6;

  localparam logic [1:0] MODE_CHORD   = 2'd0;
  localparam logic [1:0] MODE_ARP     = 2'd1;
  localparam logic [1:0] MODE_UPDOWN  = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [NOTE_W-1:0] note;
  } note_ent_t;

  typedef enum logic [2:0] {
    HC_HOLD,
    HC_CMP,
    HC_INS,
    HC_DEL,
    HC_ROT
  } held_op_t;

  typedef struct packed {
    held_op_t          op;
    logic [NOTE_W-1:0] key;
  } held_cmd_t;

  typedef enum logic [1:0] {
    SC_HOLD,
    SC_POP,
    SC_PUSH
  } snd_op_t;

  typedef struct packed {
    snd_op_t           op;
    logic [NOTE_W-1:0] note;
  } snd_cmd_t;

endpackage

FILE: design/chord_arp_if.sv
// Valid/ready channel interfaces: request items, result items, register writes.
// Depends on chord_arp_pkg for field widths.
interface chord_arp_in_if;
  logic                             valid;
  logic                             ready;
  logic [chord_arp_pkg::REQ_W-1:0]  req_type;
  logic [chord_arp_pkg::NOTE_W-1:0] key_note;
  modport source (output valid, output req_type, output key_note, input ready);
  modport sink   (input valid, input req_type, input key_note, output ready);
endinterface

interface chord_arp_out_if;
  logic                             valid;
  logic                             ready;
  logic [chord_arp_pkg::NOTE_W-1:0] out_note;
  logic [chord_arp_pkg::VEL_W-1:0]  out_velocity;
  logic                             last_event;
  modport source (output valid, output out_note, output out_velocity, output last_event,
                  input ready);
  modport sink   (input valid, input out_note, input out_velocity, input last_event,
                  output ready);
endinterface

interface chord_arp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [chord_arp_pkg::CFG_IDX_W-1:0]  index;
  logic [chord_arp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/chord_arp_held_cell.sv
// One cell of the sorted held-note chain: compare, sorted insert, delete, rotate.
// Depends on chord_arp_pkg for the entry and command types.
module chord_arp_held_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  chord_arp_pkg::held_cmd_t cmd,
  input  chord_arp_pkg::note_ent_t prev_ent,
  input  logic                    prev_after,
  input  chord_arp_pkg::note_ent_t next_ent,
  output chord_arp_pkg::note_ent_t ent,
  output logic                    after,
  output logic                    match
);

  logic                             vld_r, vld_nxt;
  logic [chord_arp_pkg::NOTE_W-1:0] note_r, note_nxt;
  logic                             gt_r, ge_r, eq_r;

  assign ent.vld  = vld_r;
  assign ent.note = note_r;
  assign after    = !vld_r || gt_r;
  assign match    = eq_r;

  always_comb begin
    vld_nxt  = vld_r;
    note_nxt = note_r;
    case (cmd.op)
      chord_arp_pkg::HC_INS: begin
        if (prev_after) begin
          vld_nxt  = prev_ent.vld;
          note_nxt = prev_ent.note;
        end else if (after) begin
          vld_nxt  = 1'b1;
          note_nxt = cmd.key;
        end
      end
      chord_arp_pkg::HC_DEL: begin
        if (ge_r) begin
          vld_nxt  = next_ent.vld;
          note_nxt = next_ent.note;
        end
      end
      chord_arp_pkg::HC_ROT: begin
        vld_nxt  = next_ent.vld;
        note_nxt = next_ent.note;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    note_r <= note_nxt;
    if (cmd.op == chord_arp_pkg::HC_CMP) begin
      gt_r <= vld_r && (note_r > cmd.key);
      ge_r <= vld_r && (note_r >= cmd.key);
      eq_r <= vld_r && (note_r == cmd.key);
    end
  end

endmodule

FILE: design/chord_arp_snd_cell.sv
// One cell of the sounding-note queue: push at the first free cell, pop toward the head.
// Depends on chord_arp_pkg for the entry and command types.
module chord_arp_snd_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  chord_arp_pkg::snd_cmd_t cmd,
  input  logic                    prev_vld,
  input  chord_arp_pkg::note_ent_t next_ent,
  output chord_arp_pkg::note_ent_t ent
);

  logic                             vld_r, vld_nxt;
  logic [chord_arp_pkg::NOTE_W-1:0] note_r, note_nxt;

  assign ent.vld  = vld_r;
  assign ent.note = note_r;

  always_comb begin
    vld_nxt  = vld_r;
    note_nxt = note_r;
    case (cmd.op)
      chord_arp_pkg::SC_POP: begin
        vld_nxt  = next_ent.vld;
        note_nxt = next_ent.note;
      end
      chord_arp_pkg::SC_PUSH: begin
        if (!vld_r && prev_vld) begin
          vld_nxt  = 1'b1;
          note_nxt = cmd.note;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    note_r <= note_nxt;
  end

endmodule

FILE: design/chord_arp_mod_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on chord_arp_pkg for the default dividend width; used by the top level for step and note index reduction.
module chord_arp_mod_unit #(
  parameter int DW = chord_arp_pkg::STEP_DIV_W,
  parameter int VW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] sh_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  assign trial = {rem_r, sh_r[DW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
    end
  end

endmodule

FILE: design/chord_arpeggiator.sv
// Chord arpeggiator top level: held-note chain, sounding queue, remainder unit, sequencer.
// Depends on chord_arp_pkg, chord_arp_if, chord_arp_held_cell, chord_arp_snd_cell,
// chord_arp_mod_unit.
//
// in_ch takes request items (note on, note off, clock tick, start, stop); out_ch gives
// note events (velocity 0 is a note off, last_event marks the final event of a request);
// cfg_ch writes the pattern registers and is always ready.
// One request is worked on at a time; in_ch is ready whenever the sequencer is idle,
// also while a finished event still waits in the output register.
// Note on/off: compare across the held chain, then insert or delete.
// Start is taken in the idle state; a stop without sounding notes passes the plan and
// finish states, a tick off the step grid only the finish state.
// Step tick: step remainder, note index remainder (arpeggio modes), one release per
// sounding note, then a rotation of the held chain over all MAX_HELD cells. The serial
// remainder unit and the rotation of the held chain set its length.
// Events leave through a one-deep output register; when the receiver stalls, the
// sequencer holds its place until the register frees up.
// Reset (synchronous, active low) empties both chains, stops the transport, clears the
// tick counter and loads the register defaults.
module chord_arpeggiator #(
  parameter int MAX_HELD  = chord_arp_pkg::MAX_HELD_DEF,
  parameter int MAX_STEPS = chord_arp_pkg::MAX_STEPS_DEF
) (
  input logic             clk,
  input logic             rst_n,
  chord_arp_in_if.sink    in_ch,
  chord_arp_out_if.source out_ch,
  chord_arp_cfg_if.sink   cfg_ch
);

  localparam int HCW = $clog2(MAX_HELD + 1);
  localparam int SPW = $clog2(2 * MAX_HELD);
  localparam int VW  = (SPW > 5) ? SPW : 5;
  localparam int TW  = $clog2(2 * MAX_HELD + chord_arp_pkg::MAX_RESULTS + 1);
  localparam int DW  = chord_arp_pkg::STEP_DIV_W;
  localparam int NW  = chord_arp_pkg::NOTE_W;
  localparam int TKW = chord_arp_pkg::TICK_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CMP   = 4'd1;
  localparam logic [3:0] ST_NOTE  = 4'd2;
  localparam logic [3:0] ST_STEP  = 4'd3;
  localparam logic [3:0] ST_STEPW = 4'd4;
  localparam logic [3:0] ST_IDX   = 4'd5;
  localparam logic [3:0] ST_IDXW  = 4'd6;
  localparam logic [3:0] ST_PLAN  = 4'd7;
  localparam logic [3:0] ST_REL   = 4'd8;
  localparam logic [3:0] ST_PLAY  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  // configuration
  logic        accomp_r;
  logic [1:0]  arp_mode_r;
  logic [6:0]  velocity_r;
  logic [4:0]  cycle_steps_r;
  logic [4:0]  pattern_len_r;
  logic [63:0] step_table_r;
  logic [2:0]  octave_r;

  // sequencer
  logic [3:0]                      state_r, state_nxt;
  logic [chord_arp_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [NW-1:0]                   key_r, key_nxt;
  logic [TKW-1:0]                  tick_r, tick_nxt;
  logic [2:0]                      mod6_r, mod6_nxt;
  logic [DW-1:0]                   div6_r, div6_nxt;
  logic                            playing_r, playing_nxt;
  logic [HCW-1:0]                  held_cnt_r, held_cnt_nxt;
  logic [HCW-1:0]                  snd_cnt_r, snd_cnt_nxt;
  logic [HCW-1:0]                  play_n_r, play_n_nxt;
  logic                            chord_r, chord_nxt;
  logic [HCW-1:0]                  k_r, k_nxt;
  logic [3:0]                      idx_r, idx_nxt;
  logic [HCW-1:0]                  rot_r, rot_nxt;
  logic [TW-1:0]                   emit_cnt_r, emit_cnt_nxt;
  logic [TW-1:0]                   last_idx_r, last_idx_nxt;

  // output register
  logic          out_vld_r;
  logic [NW-1:0] out_note_r;
  logic [6:0]    out_vel_r;
  logic          out_last_r;
  logic          out_load;
  logic [NW-1:0] out_note_nxt;
  logic [6:0]    out_vel_nxt;
  logic          out_last_nxt;
  logic          out_free;

  // chains
  chord_arp_pkg::held_cmd_t held_cmd;
  chord_arp_pkg::snd_cmd_t  snd_cmd;
  chord_arp_pkg::note_ent_t held_ent  [MAX_HELD];
  chord_arp_pkg::note_ent_t held_next [MAX_HELD];
  chord_arp_pkg::note_ent_t snd_ent   [MAX_HELD];
  chord_arp_pkg::note_ent_t snd_next  [MAX_HELD];
  logic [MAX_HELD-1:0]      held_after;
  logic [MAX_HELD-1:0]      held_match;
  logic                     dup;
  logic                     held_full;

  // remainder unit
  logic          mod_start;
  logic [DW-1:0] mod_a;
  logic [VW-1:0] mod_b;
  logic          mod_done;
  logic [VW-1:0] mod_rem;

  // step and note arithmetic
  logic [4:0]        len_cap;
  logic [3:0]        step_val;
  logic [VW-1:0]     span;
  logic [VW-1:0]     mirror;
  logic              emit_en;
  logic              hit;
  logic [TW-1:0]     total;
  logic signed [7:0] oct_semis;
  logic signed [8:0] shifted;
  logic [NW-1:0]     play_note;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.out_note     = out_note_r;
  assign out_ch.out_velocity = out_vel_r;
  assign out_ch.last_event   = out_last_r;
  assign out_free = !out_vld_r || out_ch.ready;

  assign dup       = |held_match;
  assign held_full = (held_cnt_r == HCW'(MAX_HELD));

  genvar gi;
  generate
    for (gi = 0; gi < MAX_HELD; gi++) begin : g_cell
      if (gi == MAX_HELD - 1) begin : g_tail
        assign held_next[gi] = (held_cmd.op == chord_arp_pkg::HC_ROT) ? held_ent[0] : '0;
        assign snd_next[gi]  = '0;
      end else begin : g_body
        assign held_next[gi] = held_ent[gi+1];
        assign snd_next[gi]  = snd_ent[gi+1];
      end

      if (gi == 0) begin : g_head
        chord_arp_held_cell u_held (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmd        (held_cmd),
          .prev_ent   ('0),
          .prev_after (1'b0),
          .next_ent   (held_next[gi]),
          .ent        (held_ent[gi]),
          .after      (held_after[gi]),
          .match      (held_match[gi])
        );
        chord_arp_snd_cell u_snd (
          .clk      (clk),
          .rst_n    (rst_n),
          .cmd      (snd_cmd),
          .prev_vld (1'b1),
          .next_ent (snd_next[gi]),
          .ent      (snd_ent[gi])
        );
      end else begin : g_rest
        chord_arp_held_cell u_held (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmd        (held_cmd),
          .prev_ent   (held_ent[gi-1]),
          .prev_after (held_after[gi-1]),
          .next_ent   (held_next[gi]),
          .ent        (held_ent[gi]),
          .after      (held_after[gi]),
          .match      (held_match[gi])
        );
        chord_arp_snd_cell u_snd (
          .clk      (clk),
          .rst_n    (rst_n),
          .cmd      (snd_cmd),
          .prev_vld (snd_ent[gi-1].vld),
          .next_ent (snd_next[gi]),
          .ent      (snd_ent[gi])
        );
      end
    end
  endgenerate

  chord_arp_mod_unit #(
    .DW (DW),
    .VW (VW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_a),
    .divisor  (mod_b),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign len_cap  = (pattern_len_r > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : pattern_len_r;
  assign step_val = step_table_r[{mod_rem[3:0], 2'b00} +: 4];
  assign span     = (VW'(held_cnt_r) << 1) - VW'(2);
  assign mirror   = span - mod_rem;
  assign emit_en  = (emit_cnt_r < TW'(chord_arp_pkg::MAX_RESULTS));
  assign hit      = chord_r ? (rot_r < held_cnt_r) : (rot_r == k_r);
  assign total    = TW'(snd_cnt_r) + TW'(play_n_r);

  assign oct_semis = $signed({{5{octave_r[2]}}, octave_r}) *
                     8'(chord_arp_pkg::SEMIS_PER_OCT);
  assign shifted   = $signed({2'b00, held_ent[0].note}) + $signed({oct_semis[7], oct_semis});

  always_comb begin
    if (shifted[8]) begin
      play_note = '0;
    end else if (shifted[7]) begin
      play_note = '1;
    end else begin
      play_note = shifted[NW-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    key_nxt      = key_r;
    tick_nxt     = tick_r;
    mod6_nxt     = mod6_r;
    div6_nxt     = div6_r;
    playing_nxt  = playing_r;
    held_cnt_nxt = held_cnt_r;
    snd_cnt_nxt  = snd_cnt_r;
    play_n_nxt   = play_n_r;
    chord_nxt    = chord_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    rot_nxt      = rot_r;
    emit_cnt_nxt = emit_cnt_r;
    last_idx_nxt = last_idx_r;
    held_cmd.op  = chord_arp_pkg::HC_HOLD;
    held_cmd.key = key_r;
    snd_cmd.op   = chord_arp_pkg::SC_HOLD;
    snd_cmd.note = play_note;
    mod_start    = 1'b0;
    mod_a        = div6_r;
    mod_b        = VW'(cycle_steps_r);
    out_load     = 1'b0;
    out_note_nxt = snd_ent[0].note;
    out_vel_nxt  = '0;
    out_last_nxt = (emit_cnt_r == last_idx_r);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.req_type;
          key_nxt = in_ch.key_note;
          case (in_ch.req_type)
            chord_arp_pkg::REQ_NOTE_ON, chord_arp_pkg::REQ_NOTE_OFF: begin
              state_nxt = ST_CMP;
            end
            chord_arp_pkg::REQ_TICK: begin
              if (playing_r) begin
                if (mod6_r == 3'd0) begin
                  play_n_nxt = '0;
                  if (accomp_r && (tick_r > TKW'(chord_arp_pkg::TICK_WRAP))) begin
                    tick_nxt = '0;
                    div6_nxt = '0;
                  end
                  if (accomp_r && (held_cnt_r != '0) && (cycle_steps_r != 5'd0)) begin
                    state_nxt = ST_STEP;
                  end else begin
                    state_nxt = ST_PLAN;
                  end
                end else begin
                  state_nxt = ST_FIN;
                end
              end
            end
            chord_arp_pkg::REQ_START: begin
              playing_nxt = 1'b1;
              tick_nxt    = '0;
              mod6_nxt    = '0;
              div6_nxt    = '0;
            end
            chord_arp_pkg::REQ_STOP: begin
              playing_nxt = 1'b0;
              play_n_nxt  = '0;
              state_nxt   = ST_PLAN;
            end
            default: ;
          endcase
        end
      end

      ST_CMP: begin
        held_cmd.op = chord_arp_pkg::HC_CMP;
        state_nxt   = ST_NOTE;
      end

      ST_NOTE: begin
        if (req_r == chord_arp_pkg::REQ_NOTE_ON) begin
          if (!dup && !held_full) begin
            held_cmd.op  = chord_arp_pkg::HC_INS;
            held_cnt_nxt = held_cnt_r + HCW'(1);
          end
        end else if (dup) begin
          held_cmd.op  = chord_arp_pkg::HC_DEL;
          held_cnt_nxt = held_cnt_r - HCW'(1);
        end
        state_nxt = ST_IDLE;
      end

      ST_STEP: begin
        mod_start = 1'b1;
        state_nxt = ST_STEPW;
      end

      ST_STEPW: begin
        if (mod_done) begin
          state_nxt = ST_PLAN;
          chord_nxt = 1'b0;
          if ((mod_rem < VW'(len_cap)) && (step_val != 4'd0)) begin
            idx_nxt = step_val - 4'd1;
            case (arp_mode_r)
              chord_arp_pkg::MODE_CHORD: begin
                play_n_nxt = held_cnt_r;
                chord_nxt  = 1'b1;
              end
              chord_arp_pkg::MODE_ARP: begin
                state_nxt = ST_IDX;
              end
              chord_arp_pkg::MODE_UPDOWN: begin
                if (held_cnt_r == HCW'(1)) begin
                  k_nxt      = '0;
                  play_n_nxt = HCW'(1);
                end else begin
                  state_nxt = ST_IDX;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_IDX: begin
        mod_start = 1'b1;
        mod_a     = DW'(idx_r);
        mod_b     = (arp_mode_r == chord_arp_pkg::MODE_ARP) ? VW'(held_cnt_r) : span;
        state_nxt = ST_IDXW;
      end

      ST_IDXW: begin
        if (mod_done) begin
          if (arp_mode_r == chord_arp_pkg::MODE_ARP || mod_rem < VW'(held_cnt_r)) begin
            k_nxt = mod_rem[HCW-1:0];
          end else begin
            k_nxt = mirror[HCW-1:0];
          end
          play_n_nxt = HCW'(1);
          state_nxt  = ST_PLAN;
        end
      end

      ST_PLAN: begin
        emit_cnt_nxt = '0;
        if (total == '0) begin
          state_nxt = ST_FIN;
        end else begin
          if (total > TW'(chord_arp_pkg::MAX_RESULTS)) begin
            last_idx_nxt = TW'(chord_arp_pkg::MAX_RESULTS - 1);
          end else begin
            last_idx_nxt = total - TW'(1);
          end
          state_nxt = ST_REL;
        end
      end

      ST_REL: begin
        if (snd_cnt_r == '0) begin
          rot_nxt   = '0;
          state_nxt = (play_n_r != '0) ? ST_PLAY : ST_FIN;
        end else if (!emit_en || out_free) begin
          snd_cmd.op  = chord_arp_pkg::SC_POP;
          snd_cnt_nxt = snd_cnt_r - HCW'(1);
          if (emit_en) begin
            out_load     = 1'b1;
            emit_cnt_nxt = emit_cnt_r + TW'(1);
          end
        end
      end

      ST_PLAY: begin
        if (!hit || !emit_en || out_free) begin
          held_cmd.op = chord_arp_pkg::HC_ROT;
          if (hit) begin
            snd_cmd.op = chord_arp_pkg::SC_PUSH;
            if (snd_cnt_r != HCW'(MAX_HELD)) begin
              snd_cnt_nxt = snd_cnt_r + HCW'(1);
            end
            if (emit_en) begin
              out_load     = 1'b1;
              out_note_nxt = play_note;
              out_vel_nxt  = velocity_r;
              emit_cnt_nxt = emit_cnt_r + TW'(1);
            end
          end
          rot_nxt = rot_r + HCW'(1);
          if (rot_r == HCW'(MAX_HELD - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (req_r == chord_arp_pkg::REQ_TICK) begin
          if (tick_r == '1) begin
            tick_nxt = '0;
            mod6_nxt = '0;
            div6_nxt = '0;
          end else begin
            tick_nxt = tick_r + TKW'(1);
            if (mod6_r == 3'(chord_arp_pkg::TICKS_PER_STEP - 1)) begin
              mod6_nxt = '0;
              div6_nxt = div6_r + DW'(1);
            end else begin
              mod6_nxt = mod6_r + 3'd1;
            end
          end
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tick_r     <= '0;
      mod6_r     <= '0;
      div6_r     <= '0;
      playing_r  <= 1'b0;
      held_cnt_r <= '0;
      snd_cnt_r  <= '0;
      play_n_r   <= '0;
      chord_r    <= 1'b0;
      rot_r      <= '0;
      emit_cnt_r <= '0;
      last_idx_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      mod6_r     <= mod6_nxt;
      div6_r     <= div6_nxt;
      playing_r  <= playing_nxt;
      held_cnt_r <= held_cnt_nxt;
      snd_cnt_r  <= snd_cnt_nxt;
      play_n_r   <= play_n_nxt;
      chord_r    <= chord_nxt;
      rot_r      <= rot_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      last_idx_r <= last_idx_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    key_r <= key_nxt;
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    if (out_load) begin
      out_note_r <= out_note_nxt;
      out_vel_r  <= out_vel_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accomp_r      <= 1'b0;
      arp_mode_r    <= chord_arp_pkg::MODE_CHORD;
      velocity_r    <= chord_arp_pkg::VEL_RESET;
      cycle_steps_r <= 5'(chord_arp_pkg::MAX_STEPS_DEF);
      pattern_len_r <= 5'(chord_arp_pkg::MAX_STEPS_DEF);
      step_table_r  <= '0;
      octave_r      <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        chord_arp_pkg::REG_ACCOMP_ENABLE:  accomp_r      <= cfg_ch.data[0];
        chord_arp_pkg::REG_ARP_MODE:       arp_mode_r    <= cfg_ch.data[1:0];
        chord_arp_pkg::REG_NOTE_VELOCITY:  velocity_r    <= cfg_ch.data[6:0];
        chord_arp_pkg::REG_CYCLE_STEPS:    cycle_steps_r <= cfg_ch.data[4:0];
        chord_arp_pkg::REG_PATTERN_LENGTH: pattern_len_r <= cfg_ch.data[4:0];
        chord_arp_pkg::REG_STEP_TABLE:     step_table_r  <= cfg_ch.data;
        chord_arp_pkg::REG_OCTAVE_SHIFT:   octave_r      <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

endmodule
